/* sv/msgc_pkg.sv */
package msgc_pkg;

    localparam int REG_STOPS = 7;
    localparam int POS_W     = 16;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int COLOR_W   = NUM_CH * CH_W;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W     = CH_W + POS_W;
    localparam int STOP_POS_LSB = COLOR_W;

    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = 3'd1;

    // one blend job: an end color is sent as pcol == ncol, ofs 0, rng 1
    typedef struct packed {
        logic [COLOR_W-1:0] pcol;
        logic [COLOR_W-1:0] ncol;
        logic [POS_W-1:0]   ofs;
        logic [POS_W-1:0]   rng;
    } t_job;

endpackage

/* sv/msgc_ifs.sv */
interface msgc_pos_if;
    logic        valid;
    logic        ready;
    logic [15:0] position;
    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

interface msgc_color_if;
    logic        valid;
    logic        ready;
    logic [31:0] color;
    modport source (output valid, output color, input ready);
    modport sink   (input valid, input color, output ready);
endinterface

/* sv/msgc_front.sv */
module msgc_front #(
    parameter int MAX_STOPS     = 7,
    parameter int POSITION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [msgc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msgc_pkg::CFG_W-1:0]      i_cfg_data,
    msgc_pos_if.sink                        i_pos,
    output logic                            o_job_valid,
    input  logic                            i_job_ready,
    output msgc_pkg::t_job                  o_job
);
    import msgc_pkg::*;

    localparam logic [POS_W-1:0] POS_MASK = POS_W'((32'd1 << POSITION_BITS) - 32'd1);
    localparam logic [2:0]       MAX_CNT  = 3'(MAX_STOPS);

    logic [2:0]       r_cnt;
    logic [CFG_W-1:0] r_stop [0:REG_STOPS-1];
    logic             r_fv;
    t_job             r_job;
    t_job             n_job;

    logic [2:0]       cnt;
    logic [POS_W-1:0] pos_m;
    logic [POS_W-1:0] sp [0:REG_STOPS-1];
    logic [2:0]       idx;
    logic             found;
    logic [POS_W-1:0] pp, np, ofs;
    logic             take;

    assign take        = !r_fv || i_job_ready;
    assign i_pos.ready = take;
    assign o_job_valid = r_fv;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < REG_STOPS; i++) r_stop[i] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_STOP_COUNT) begin
                r_cnt <= i_cfg_data[2:0];
            end else begin
                r_stop[i_cfg_idx - REG_STOP_FIRST] <= i_cfg_data;
            end
        end
    end

    always_comb begin
        cnt   = (r_cnt > MAX_CNT) ? MAX_CNT : r_cnt;
        pos_m = i_pos.position & POS_MASK;
        for (int i = 0; i < REG_STOPS; i++) begin
            sp[i] = r_stop[i][STOP_POS_LSB +: POS_W] & POS_MASK;
        end
        // first used stop not below the position
        found = 1'b0;
        idx   = cnt;
        for (int i = 0; i < REG_STOPS; i++) begin
            if (!found && 3'(i) < cnt && sp[i] >= pos_m) begin
                found = 1'b1;
                idx   = 3'(i);
            end
        end
        pp = sp[idx - 3'd1];
        np = sp[idx];
        ofs = pos_m - pp;

        n_job.ofs  = '0;
        n_job.rng  = POS_W'(1);
        n_job.pcol = r_stop[0][COLOR_W-1:0];
        if (cnt == 3'd0) begin
            n_job.pcol = '0;
        end else if (cnt == 3'd1 || idx == 3'd0) begin
            n_job.pcol = r_stop[0][COLOR_W-1:0];
        end else if (idx >= cnt) begin
            n_job.pcol = r_stop[cnt - 3'd1][COLOR_W-1:0];
        end else if (np <= pp) begin
            n_job.pcol = r_stop[idx - 3'd1][COLOR_W-1:0];
        end else begin
            n_job.pcol = r_stop[idx - 3'd1][COLOR_W-1:0];
            n_job.rng  = np - pp;
            n_job.ofs  = (ofs > np - pp) ? np - pp : ofs;
        end
        n_job.ncol = (n_job.ofs == '0) ? n_job.pcol : r_stop[idx][COLOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (take) begin
            r_fv <= i_pos.valid;
        end
        if (take && i_pos.valid) begin
            r_job <= n_job;
        end
    end

endmodule

/* sv/msgc_fifo.sv */
module msgc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  msgc_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_pop,
    output msgc_pkg::t_job o_job
);
    import msgc_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) r_mem[r_wp] <= i_job;
    end

endmodule

/* sv/msgc_back.sv */
module msgc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_pop,
    input  msgc_pkg::t_job i_job,
    msgc_color_if.source   o_color
);
    import msgc_pkg::*;

    localparam int STG = CH_W;

    logic             adv;
    logic             r_mv;
    logic [NUM_W-1:0] r_num [0:NUM_CH-1];
    logic [POS_W-1:0] r_mrng;
    logic             r_dv  [0:STG-1];
    logic [NUM_W-1:0] r_rem [0:STG-1][0:NUM_CH-1];
    logic [CH_W-1:0]  r_q   [0:STG-1][0:NUM_CH-1];
    logic [POS_W-1:0] r_drng [0:STG-1];

    logic [NUM_W-1:0] n_num [0:NUM_CH-1];
    logic [NUM_W-1:0] n_rem [0:STG-1][0:NUM_CH-1];
    logic [CH_W-1:0]  n_q   [0:STG-1][0:NUM_CH-1];
    logic [NUM_W-1:0] in_rem [0:STG-1][0:NUM_CH-1];
    logic [CH_W-1:0]  in_q   [0:STG-1][0:NUM_CH-1];
    logic [POS_W-1:0] in_rng [0:STG-1];
    logic [NUM_W-1:0] dsh [0:STG-1];
    logic [POS_W-1:0] wgt_p;

    assign adv           = !r_dv[STG-1] || o_color.ready;
    assign o_pop         = adv;
    assign o_color.valid = r_dv[STG-1];
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            o_color.color[c*CH_W +: CH_W] = r_q[STG-1][c];
        end
    end

    // prev*(rng-ofs) + next*ofs, per channel
    always_comb begin
        wgt_p = i_job.rng - i_job.ofs;
        for (int c = 0; c < NUM_CH; c++) begin
            n_num[c] = NUM_W'(i_job.pcol[c*CH_W +: CH_W]) * NUM_W'(wgt_p)
                     + NUM_W'(i_job.ncol[c*CH_W +: CH_W]) * NUM_W'(i_job.ofs);
        end
    end

    // restoring division, one quotient bit per stage, msb first
    always_comb begin
        for (int s = 0; s < STG; s++) begin
            in_rng[s] = (s == 0) ? r_mrng : r_drng[(s == 0) ? 0 : s - 1];
            dsh[s]    = NUM_W'(in_rng[s]) << (STG - 1 - s);
            for (int c = 0; c < NUM_CH; c++) begin
                in_rem[s][c] = (s == 0) ? r_num[c] : r_rem[(s == 0) ? 0 : s - 1][c];
                in_q[s][c]   = (s == 0) ? '0 : r_q[(s == 0) ? 0 : s - 1][c];
                n_rem[s][c]  = in_rem[s][c];
                n_q[s][c]    = in_q[s][c];
                if (in_rem[s][c] >= dsh[s]) begin
                    n_rem[s][c]            = in_rem[s][c] - dsh[s];
                    n_q[s][c][STG - 1 - s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            for (int s = 0; s < STG; s++) r_dv[s] <= 1'b0;
        end else if (adv) begin
            r_mv    <= i_valid;
            r_dv[0] <= r_mv;
            for (int s = 1; s < STG; s++) r_dv[s] <= r_dv[s-1];
        end
        if (adv) begin
            r_mrng <= i_job.rng;
            for (int c = 0; c < NUM_CH; c++) r_num[c] <= n_num[c];
            for (int s = 0; s < STG; s++) begin
                r_drng[s] <= in_rng[s];
                for (int c = 0; c < NUM_CH; c++) begin
                    r_rem[s][c] <= n_rem[s][c];
                    r_q[s][c]   <= n_q[s][c];
                end
            end
        end
    end

endmodule

/* sv/multi_stop_gradient_color.sv */
// multi-stop gradient color: 16-bit position beats in, 32-bit 4-channel color
// beats out, one per cycle while the color output is not stalled. A beat passes
// a registered stop search in the front, a 2-entry queue, a multiply register
// and eight divider stages (one quotient bit each) in the back. The user writes
// stop registers through the cfg port only while no beats are in flight, which
// the block does not enforce; index 0 is the stop count, 1 to 7 are the stops.
module multi_stop_gradient_color #(
    parameter int MAX_STOPS     = 7,
    parameter int POSITION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [msgc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msgc_pkg::CFG_W-1:0]      i_cfg_data,
    msgc_pos_if.sink                        i_pos,
    msgc_color_if.source                    o_color
);
    import msgc_pkg::*;

    logic f_valid, f_ready, q_valid, q_pop;
    t_job f_job, q_job;

    msgc_front #(
        .MAX_STOPS     (MAX_STOPS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pos       (i_pos),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    msgc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    msgc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_job   (q_job),
        .o_color (o_color)
    );

endmodule
